@@ src/assert_macros.svh @@
// Assertion helpers; clk_i and rst_ni are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sha256 check failed");
`define SHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha256 check failed");
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha256 check failed");
`else
`define SHA_ASSERT(lbl, prop)
`define SHA_ASSERT_IMP(lbl, ante, cons)
`define SHA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/sha256_pkg.sv @@
package sha256_pkg;

  typedef enum logic [2:0] {
    PUSH_NONE,
    PUSH_DATA,
    PUSH_MARK,
    PUSH_ZERO,
    PUSH_LEN_HI,
    PUSH_LEN_LO
  } push_sel_e;

  typedef struct packed {
    push_sel_e  push;
    logic       count;
    logic       round;
    logic [5:0] rnd;
    logic       feed;
    logic       clear;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fills;
    logic at_len;
    logic last_full;
  } dp_status_t;

  localparam logic [31:0] MARK_WORD = 32'h8000_0000;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

endpackage

@@ src/sha256_dp.sv @@
module sha256_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_pkg::dp_cmd_t    cmd_i,
  output sha256_pkg::dp_status_t status_o,
  input  logic [31:0]            data_word_i,
  input  logic [2:0]             valid_bytes_i,
  input  logic                   last_item_i,
  output logic [31:0]            digest_word_o,
  output logic [2:0]             word_index_o,
  output logic                   last_word_o
);

  localparam logic [31:0] MARK_WORD_LOCAL = sha256_pkg::MARK_WORD;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  logic [31:0] win_q   [16];
  logic [31:0] win_d   [16];
  logic [31:0] var_q   [8];
  logic [31:0] var_d   [8];
  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];
  logic [60:0] bytes_q, bytes_d;
  logic [3:0]  wib_q, wib_d;

  logic [2:0]  nvalid;
  logic [31:0] last_word_val;
  logic [31:0] push_word;
  logic [31:0] t1, t2;

  // clamp oversize byte counts to a full word
  assign nvalid = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;

  always_comb begin
    unique case (nvalid)
      3'd0:    last_word_val = MARK_WORD_LOCAL;
      3'd1:    last_word_val = {data_word_i[31:24], 8'h80, 16'h0000};
      3'd2:    last_word_val = {data_word_i[31:16], 8'h80, 8'h00};
      3'd3:    last_word_val = {data_word_i[31:8], 8'h80};
      default: last_word_val = data_word_i;
    endcase
  end

  always_comb begin
    unique case (cmd_i.push)
      sha256_pkg::PUSH_DATA:   push_word = last_item_i ? last_word_val : data_word_i;
      sha256_pkg::PUSH_MARK:   push_word = MARK_WORD_LOCAL;
      sha256_pkg::PUSH_LEN_HI: push_word = bytes_q[60:29];
      sha256_pkg::PUSH_LEN_LO: push_word = {bytes_q[28:0], 3'b000};
      default:                 push_word = 32'h0;
    endcase
  end

  assign t1 = var_q[7] + big_sigma1(var_q[4])
            + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
            + sha256_pkg::ROUND_K[cmd_i.rnd] + win_q[0];
  assign t2 = big_sigma0(var_q[0])
            + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

  always_comb begin
    win_d   = win_q;
    var_d   = var_q;
    chain_d = chain_q;
    bytes_d = bytes_q;
    wib_d   = wib_q;

    if (cmd_i.push != sha256_pkg::PUSH_NONE) begin
      for (int i = 0; i < 15; i++) win_d[i] = win_q[i+1];
      win_d[15] = push_word;
      wib_d     = wib_q + 4'd1;
      // block complete: load working variables for the rounds
      if (wib_q == 4'd15) var_d = chain_q;
    end

    if (cmd_i.round) begin
      // window holds W[t..t+15]; append W[t+16]
      for (int i = 0; i < 15; i++) win_d[i] = win_q[i+1];
      win_d[15] = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
      var_d[7] = var_q[6];
      var_d[6] = var_q[5];
      var_d[5] = var_q[4];
      var_d[4] = var_q[3] + t1;
      var_d[3] = var_q[2];
      var_d[2] = var_q[1];
      var_d[1] = var_q[0];
      var_d[0] = t1 + t2;
    end

    if (cmd_i.feed) begin
      for (int i = 0; i < 8; i++) chain_d[i] = chain_q[i] + var_q[i];
    end

    if (cmd_i.count) begin
      bytes_d = bytes_q + (last_item_i ? {58'b0, nvalid} : 61'd4);
    end

    if (cmd_i.clear) begin
      chain_d = sha256_pkg::INIT_HASH;
      bytes_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha256_pkg::INIT_HASH;
      bytes_q <= '0;
      wib_q   <= '0;
    end else begin
      chain_q <= chain_d;
      bytes_q <= bytes_d;
      wib_q   <= wib_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    var_q <= var_d;
  end

  assign status_o.fills     = (wib_q == 4'd15);
  assign status_o.at_len    = (wib_q == 4'd14);
  assign status_o.last_full = (nvalid == 3'd4);

  assign digest_word_o = chain_q[cmd_i.out_idx];
  assign word_index_o  = cmd_i.out_idx;
  assign last_word_o   = (cmd_i.out_idx == 3'd7);

endmodule

@@ src/sha256_ctrl.sv @@
module sha256_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   last_item_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  sha256_pkg::dp_status_t status_i,
  output sha256_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN_LO,
    PH_DONE
  } phase_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic       fin_q, fin_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    fin_d   = fin_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;

    cmd_o         = '0;
    cmd_o.push    = sha256_pkg::PUSH_NONE;
    cmd_o.rnd     = rnd_q;
    cmd_o.out_idx = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.push  = sha256_pkg::PUSH_DATA;
          cmd_o.count = 1'b1;
          if (last_item_i) begin
            fin_d   = 1'b1;
            phase_d = status_i.last_full ? PH_MARK : PH_ZERO;
          end
          if (status_i.fills) state_d = ST_ROUND;
          else if (last_item_i) state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        unique case (phase_q)
          PH_MARK: begin
            cmd_o.push = sha256_pkg::PUSH_MARK;
            phase_d    = PH_ZERO;
          end
          PH_ZERO: begin
            if (status_i.at_len) begin
              cmd_o.push = sha256_pkg::PUSH_LEN_HI;
              phase_d    = PH_LEN_LO;
            end else begin
              cmd_o.push = sha256_pkg::PUSH_ZERO;
            end
          end
          PH_LEN_LO: begin
            cmd_o.push = sha256_pkg::PUSH_LEN_LO;
            phase_d    = PH_DONE;
          end
          default: begin
            cmd_o.push = sha256_pkg::PUSH_NONE;
          end
        endcase
        if (status_i.fills && cmd_o.push != sha256_pkg::PUSH_NONE) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = ST_FEED;
      end
      ST_FEED: begin
        cmd_o.feed = 1'b1;
        if (!fin_q) state_d = ST_IDLE;
        else if (phase_q == PH_DONE) state_d = ST_OUT;
        else state_d = ST_PAD;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.clear = 1'b1;
            fin_d       = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_ZERO;
      fin_q   <= 1'b0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fin_q   <= fin_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ src/sha256_message_digest_top.sv @@
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    data_word_i, valid_bytes_i, last_item_i
// out       output     out_valid_o / out_stall_i  digest_word_o, word_index_o, last_word_o
//
// An ordinary word is accepted while the core is idle; the sixteenth word of a block then stalls
// the input through 64 rounds in the single round unit and one feed-forward.
// A last word is followed by the padding words, one or two compressions and eight output beats.
// Reset loads the initial hash and clears the byte and word counters at once.
// The digest is held while out_stall_i is high; no input is taken until it drains.
`include "assert_macros.svh"

module sha256_message_digest_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha256_pkg::dp_cmd_t    cmd;
  sha256_pkg::dp_status_t status;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .last_item_i   (last_item_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  `SHA_ASSERT(a_no_input_during_digest, !(out_valid_o && !in_stall_o))
  `SHA_ASSERT_IMP(a_round_excludes_push, cmd.round, cmd.push == sha256_pkg::PUSH_NONE)
  `SHA_ASSERT_IMP(a_feed_after_rounds, $fell(cmd.round), cmd.feed)
  `SHA_ASSERT_NEXT(a_digest_ends, out_valid_o && !out_stall_i && last_word_o, !out_valid_o)

endmodule
